// ----- rtl/i2cm_pkg.sv -----
package i2cm_pkg;

  // Command codes on the operation field
  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_WAIT  = 3'd3,
    OP_READ  = 3'd4,
    OP_ACK   = 3'd5,
    OP_NACK  = 3'd6
  } op_t;

  // Line sequencer phases, one-hot
  typedef enum logic [17:0] {
    PH_IDLE    = 18'h00001,
    PH_START1  = 18'h00002,
    PH_START2  = 18'h00004,
    PH_STOP1   = 18'h00008,
    PH_STOP2   = 18'h00010,
    PH_WR_HI   = 18'h00020,
    PH_WR_LO   = 18'h00040,
    PH_WA_SCL  = 18'h00080,
    PH_WA_POLL = 18'h00100,
    PH_WA_S1   = 18'h00200,
    PH_WA_S2   = 18'h00400,
    PH_WA_S3   = 18'h00800,
    PH_RD_HI   = 18'h01000,
    PH_RD_LO   = 18'h02000,
    PH_AK_SDA  = 18'h04000,
    PH_AK_HI   = 18'h08000,
    PH_AK_LO   = 18'h10000,
    PH_AK_REL  = 18'h20000
  } phase_t;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
  localparam logic [3:0] BITS_PER_BYTE   = 4'd8;
  localparam logic [8:0] WAIT_CNT_MAX    = 9'd511;

  // Sequencer state
  typedef struct packed {
    phase_t     phase;
    logic [7:0] shreg;
    logic [3:0] bit_cnt;
    logic [8:0] wait_cnt;
    logic       ack_choice;
    logic       scl;
    logic       sda;
  } seq_state_t;

  // One tick in
  typedef struct packed {
    logic       command_valid;
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       send_ack_after_read;
    logic       sda_sample;
  } tick_in_t;

  // One result out
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_failed;
  } tick_out_t;

endpackage

// ----- rtl/i2cm_if.sv -----
// Input channel: one half-bit tick per transaction
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic       command_valid;
  logic [2:0] operation;
  logic [7:0] write_data;
  logic       send_ack_after_read;
  logic       sda_sample;

  modport source (
    output valid, command_valid, operation, write_data, send_ack_after_read, sda_sample,
    input  ready
  );
  modport sink (
    input  valid, command_valid, operation, write_data, send_ack_after_read, sda_sample,
    output ready
  );
endinterface

// Result channel: line levels and status per tick
interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_failed;

  modport source (
    output valid, scl_level, sda_level, busy_res, done_res, read_data, ack_failed,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_level, busy_res, done_res, read_data, ack_failed,
    output ready
  );
endinterface

// ----- rtl/i2c_master_bit_sequencer.sv -----
// I2C master line sequencer, one half-bit tick per input transaction.
// Latency: the result of a tick is valid on the cycle after it is accepted.
// Throughput: one tick per cycle; the single result register is refilled in
// the cycle it is taken, so input ready only drops while a result is stalled.
// Reset (rst_n low, synchronous): idle phase, SCL and SDA released high,
// counters and shift register cleared, ack_timeout back to 250, no result.
module i2c_master_bit_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  i2cm_in_if.sink    in_ch,
  i2cm_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import i2cm_pkg::*;

  seq_state_t state_r;
  seq_state_t state_nxt;
  tick_in_t   tick;
  tick_out_t  res;
  tick_out_t  out_r;
  logic       out_valid_r;
  logic [7:0] ack_timeout_r;
  logic       in_acc;

  // Accept a tick whenever the result register is empty or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign tick.command_valid       = in_ch.command_valid;
  assign tick.operation           = in_ch.operation;
  assign tick.write_data          = in_ch.write_data;
  assign tick.send_ack_after_read = in_ch.send_ack_after_read;
  assign tick.sda_sample          = in_ch.sda_sample;

  i2cm_step u_step (
    .st          (state_r),
    .tick        (tick),
    .ack_timeout (ack_timeout_r),
    .st_nxt      (state_nxt),
    .res         (res)
  );

  // Timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      ack_timeout_r <= cfg_wdata;
    end
  end

  // Sequencer state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase      <= PH_IDLE;
      state_r.shreg      <= '0;
      state_r.bit_cnt    <= '0;
      state_r.wait_cnt   <= '0;
      state_r.ack_choice <= 1'b0;
      state_r.scl        <= 1'b1;
      state_r.sda        <= 1'b1;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.scl_level  = out_r.scl_level;
  assign out_ch.sda_level  = out_r.sda_level;
  assign out_ch.busy_res   = out_r.busy_res;
  assign out_ch.done_res   = out_r.done_res;
  assign out_ch.read_data  = out_r.read_data;
  assign out_ch.ack_failed = out_r.ack_failed;

endmodule

// ----- rtl/i2cm_step.sv -----
// Next-state and result logic for one half-bit tick
module i2cm_step (
  input  i2cm_pkg::seq_state_t st,
  input  i2cm_pkg::tick_in_t   tick,
  input  logic [7:0]           ack_timeout,
  output i2cm_pkg::seq_state_t st_nxt,
  output i2cm_pkg::tick_out_t  res
);
  import i2cm_pkg::*;

  logic       done;
  logic       fail;
  logic [8:0] wait_inc;
  logic [3:0] bit_inc;

  assign wait_inc = (st.wait_cnt != WAIT_CNT_MAX) ? st.wait_cnt + 9'd1 : st.wait_cnt;
  assign bit_inc  = st.bit_cnt + 4'd1;

  always_comb begin
    st_nxt = st;
    done   = 1'b0;
    fail   = 1'b0;
    unique case (st.phase)
      PH_IDLE: begin
        if (tick.command_valid) begin
          unique case (tick.operation)
            OP_START: begin
              st_nxt.sda   = 1'b1;
              st_nxt.scl   = 1'b1;
              st_nxt.phase = PH_START1;
            end
            OP_STOP: begin
              st_nxt.sda   = 1'b0;
              st_nxt.phase = PH_STOP1;
            end
            OP_WRITE: begin
              st_nxt.sda     = tick.write_data[7];
              st_nxt.shreg   = {tick.write_data[6:0], 1'b0};
              st_nxt.bit_cnt = 4'd1;
              st_nxt.phase   = PH_WR_HI;
            end
            OP_WAIT: begin
              st_nxt.sda      = 1'b1;
              st_nxt.wait_cnt = '0;
              st_nxt.phase    = PH_WA_SCL;
            end
            OP_READ: begin
              // first data bit is sampled on the next tick with SCL high
              st_nxt.scl        = 1'b1;
              st_nxt.shreg      = '0;
              st_nxt.bit_cnt    = '0;
              st_nxt.ack_choice = tick.send_ack_after_read;
              st_nxt.phase      = PH_RD_LO;
            end
            OP_ACK: begin
              st_nxt.ack_choice = 1'b1;
              st_nxt.sda        = 1'b0;
              st_nxt.phase      = PH_AK_HI;
            end
            OP_NACK: begin
              st_nxt.ack_choice = 1'b0;
              st_nxt.sda        = 1'b1;
              st_nxt.phase      = PH_AK_HI;
            end
            default: st_nxt.phase = PH_IDLE;
          endcase
        end
      end
      PH_START1: begin
        st_nxt.sda   = 1'b0;
        st_nxt.phase = PH_START2;
      end
      PH_START2: begin
        st_nxt.scl = 1'b0;
        done       = 1'b1;
      end
      PH_STOP1: begin
        st_nxt.scl   = 1'b1;
        st_nxt.phase = PH_STOP2;
      end
      PH_STOP2: begin
        st_nxt.sda = 1'b1;
        done       = 1'b1;
      end
      PH_WR_HI: begin
        st_nxt.scl   = 1'b1;
        st_nxt.phase = PH_WR_LO;
      end
      PH_WR_LO: begin
        st_nxt.scl = 1'b0;
        if (st.bit_cnt < BITS_PER_BYTE) begin
          st_nxt.sda     = st.shreg[7];
          st_nxt.shreg   = {st.shreg[6:0], 1'b0};
          st_nxt.bit_cnt = bit_inc;
          st_nxt.phase   = PH_WR_HI;
        end else begin
          // release SDA for the slave acknowledge
          st_nxt.sda = 1'b1;
          done       = 1'b1;
        end
      end
      PH_WA_SCL: begin
        st_nxt.scl   = 1'b1;
        st_nxt.phase = PH_WA_POLL;
      end
      PH_WA_POLL: begin
        if (!tick.sda_sample) begin
          st_nxt.scl = 1'b0;
          done       = 1'b1;
        end else begin
          // saturating poll count, timeout runs a stop sequence
          st_nxt.wait_cnt = wait_inc;
          if (wait_inc > {1'b0, ack_timeout}) begin
            st_nxt.sda   = 1'b0;
            st_nxt.phase = PH_WA_S1;
          end
        end
      end
      PH_WA_S1: begin
        st_nxt.scl   = 1'b1;
        st_nxt.phase = PH_WA_S2;
      end
      PH_WA_S2: begin
        st_nxt.sda   = 1'b1;
        st_nxt.phase = PH_WA_S3;
      end
      PH_WA_S3: begin
        st_nxt.scl = 1'b0;
        done       = 1'b1;
        fail       = 1'b1;
      end
      PH_RD_HI: begin
        st_nxt.scl   = 1'b1;
        st_nxt.phase = PH_RD_LO;
      end
      PH_RD_LO: begin
        st_nxt.shreg   = {st.shreg[6:0], tick.sda_sample};
        st_nxt.scl     = 1'b0;
        st_nxt.bit_cnt = bit_inc;
        st_nxt.phase   = bit_inc[3] ? PH_AK_SDA : PH_RD_HI;
      end
      PH_AK_SDA: begin
        st_nxt.sda   = ~st.ack_choice;
        st_nxt.phase = PH_AK_HI;
      end
      PH_AK_HI: begin
        st_nxt.scl   = 1'b1;
        st_nxt.phase = PH_AK_LO;
      end
      PH_AK_LO: begin
        st_nxt.scl = 1'b0;
        if (st.ack_choice) begin
          st_nxt.phase = PH_AK_REL;
        end else begin
          done = 1'b1;
        end
      end
      PH_AK_REL: begin
        st_nxt.sda = 1'b1;
        done       = 1'b1;
      end
      default: st_nxt.phase = PH_IDLE;
    endcase
    if (done) begin
      st_nxt.phase = PH_IDLE;
    end
  end

  // Result of this tick
  assign res.scl_level  = st_nxt.scl;
  assign res.sda_level  = st_nxt.sda;
  assign res.busy_res   = (st_nxt.phase != PH_IDLE);
  assign res.done_res   = done;
  assign res.read_data  = st_nxt.shreg;
  assign res.ack_failed = fail;

endmodule

// ----- rtl/i2cm_checker.sv -----
// Port-level checks for the I2C line sequencer
module i2cm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_busy,
  input logic        out_done,
  input logic        out_fail,
  input logic [11:0] out_payload
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("stalled result changed");

  // No new tick is taken while the result register is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input ready while result stalled");

  // A completing command leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done |-> !out_busy)
    else $error("done with busy set");

  // Failure is only reported on a done tick
  a_fail_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fail |-> out_done)
    else $error("ack failure without done");

  // Every accepted tick yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick produced no result");

endmodule

bind i2c_master_bit_sequencer i2cm_checker u_i2cm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_busy    (out_ch.busy_res),
  .out_done    (out_ch.done_res),
  .out_fail    (out_ch.ack_failed),
  .out_payload ({out_ch.scl_level, out_ch.sda_level, out_ch.busy_res,
                 out_ch.done_res, out_ch.read_data})
);

// ----- test/tb_i2c_master_bit_sequencer.sv -----
module tb_i2c_master_bit_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  // Operation code the block must ignore
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned N_PHASES = 4;

  // Expected line levels on an idle tick right after reset
  localparam tick_out_t IDLE_LINES = '{scl_level: 1'b1, sda_level: 1'b1, busy_res: 1'b0,
                                       done_res: 1'b0, read_data: 8'h00, ack_failed: 1'b0};
  // First step of a start condition: both lines released, sequence running
  localparam tick_out_t START_STEP = '{scl_level: 1'b1, sda_level: 1'b1, busy_res: 1'b1,
                                       done_res: 1'b0, read_data: 8'h00, ack_failed: 1'b0};

  // One directed row: a tick, then trailing ticks with no command
  typedef struct packed {
    logic       cv;
    logic [2:0] op;
    logic [7:0] wd;
    logic       ak;
    logic       sda;
    logic [9:0] trail;
    logic       typed;
    tick_out_t  want;
  } dir_row_t;

  // Mirror of the sequencer state
  typedef struct {
    phase_t     ph;
    logic [7:0] shreg;
    logic [3:0] nbits;
    logic [8:0] polls;
    logic       ack_bit;
    logic       scl;
    logic       sda;
  } line_state_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  i2cm_in_if  in_ch ();
  i2cm_out_if out_ch ();

  i2c_master_bit_sequencer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  line_state_t line_st;
  logic [7:0]  timeout_reg;
  tick_out_t   pending_lines [$];
  int unsigned mismatch_count = 0;
  int unsigned n_ticks = 0;
  int unsigned n_cmds = 0;
  int unsigned n_done_seen = 0;
  int unsigned n_fail_seen = 0;
  int unsigned n_cfg_writes = 0;
  int unsigned hold_requests = 0;
  bit          gaps_on = 1'b1;

  dir_row_t dir_rows [0:15] = '{
    '{1'b0, OP_START,  8'h00, 1'b0, 1'b1, 10'd0,   1'b1, IDLE_LINES},
    '{1'b1, OP_UNUSED, 8'hFF, 1'b1, 1'b1, 10'd0,   1'b1, IDLE_LINES},
    '{1'b1, OP_START,  8'h00, 1'b0, 1'b1, 10'd2,   1'b1, START_STEP},
    '{1'b1, OP_WRITE,  8'hFF, 1'b0, 1'b1, 10'd16,  1'b0, IDLE_LINES},
    '{1'b1, OP_WAIT,   8'h00, 1'b0, 1'b0, 10'd2,   1'b0, IDLE_LINES},
    '{1'b1, OP_WRITE,  8'hA5, 1'b1, 1'b0, 10'd16,  1'b0, IDLE_LINES},
    '{1'b1, OP_WAIT,   8'h00, 1'b0, 1'b1, 10'd258, 1'b0, IDLE_LINES},
    '{1'b1, OP_WRITE,  8'h00, 1'b0, 1'b1, 10'd16,  1'b0, IDLE_LINES},
    '{1'b1, OP_START,  8'h00, 1'b0, 1'b1, 10'd0,   1'b0, IDLE_LINES},
    '{1'b1, OP_STOP,   8'h00, 1'b0, 1'b1, 10'd1,   1'b0, IDLE_LINES},
    '{1'b1, OP_READ,   8'h00, 1'b1, 1'b1, 10'd19,  1'b0, IDLE_LINES},
    '{1'b1, OP_READ,   8'hFF, 1'b0, 1'b0, 10'd18,  1'b0, IDLE_LINES},
    '{1'b1, OP_ACK,    8'h00, 1'b0, 1'b1, 10'd3,   1'b0, IDLE_LINES},
    '{1'b1, OP_NACK,   8'h00, 1'b1, 1'b1, 10'd2,   1'b0, IDLE_LINES},
    '{1'b1, OP_STOP,   8'h00, 1'b0, 1'b1, 10'd2,   1'b0, IDLE_LINES},
    '{1'b0, OP_START,  8'h00, 1'b0, 1'b1, 10'd0,   1'b1, IDLE_LINES}
  };

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the line sequencer by one half-bit tick
  function automatic tick_out_t advance_line(input tick_in_t t);
    tick_out_t r;
    logic      fin;
    logic      fail;
    fin  = 1'b0;
    fail = 1'b0;
    case (line_st.ph)
      PH_IDLE: begin
        if (t.command_valid) begin
          case (t.operation)
            OP_START: begin
              line_st.sda = 1'b1;
              line_st.scl = 1'b1;
              line_st.ph  = PH_START1;
            end
            OP_STOP: begin
              line_st.sda = 1'b0;
              line_st.ph  = PH_STOP1;
            end
            OP_WRITE: begin
              line_st.sda   = t.write_data[7];
              line_st.shreg = {t.write_data[6:0], 1'b0};
              line_st.nbits = 4'd1;
              line_st.ph    = PH_WR_HI;
            end
            OP_WAIT: begin
              line_st.sda   = 1'b1;
              line_st.polls = '0;
              line_st.ph    = PH_WA_SCL;
            end
            OP_READ: begin
              line_st.scl     = 1'b1;
              line_st.shreg   = '0;
              line_st.nbits   = '0;
              line_st.ack_bit = t.send_ack_after_read;
              line_st.ph      = PH_RD_LO;
            end
            OP_ACK: begin
              line_st.ack_bit = 1'b1;
              line_st.sda     = 1'b0;
              line_st.ph      = PH_AK_HI;
            end
            OP_NACK: begin
              line_st.ack_bit = 1'b0;
              line_st.sda     = 1'b1;
              line_st.ph      = PH_AK_HI;
            end
            default: ;
          endcase
        end
      end
      PH_START1: begin
        line_st.sda = 1'b0;
        line_st.ph  = PH_START2;
      end
      PH_START2: begin
        line_st.scl = 1'b0;
        fin = 1'b1;
      end
      PH_STOP1: begin
        line_st.scl = 1'b1;
        line_st.ph  = PH_STOP2;
      end
      PH_STOP2: begin
        line_st.sda = 1'b1;
        fin = 1'b1;
      end
      PH_WR_HI: begin
        line_st.scl = 1'b1;
        line_st.ph  = PH_WR_LO;
      end
      PH_WR_LO: begin
        line_st.scl = 1'b0;
        if (line_st.nbits < BITS_PER_BYTE) begin
          line_st.sda   = line_st.shreg[7];
          line_st.shreg = {line_st.shreg[6:0], 1'b0};
          line_st.nbits = line_st.nbits + 4'd1;
          line_st.ph    = PH_WR_HI;
        end else begin
          line_st.sda = 1'b1;
          fin = 1'b1;
        end
      end
      PH_WA_SCL: begin
        line_st.scl = 1'b1;
        line_st.ph  = PH_WA_POLL;
      end
      PH_WA_POLL: begin
        if (!t.sda_sample) begin
          line_st.scl = 1'b0;
          fin = 1'b1;
        end else begin
          if (line_st.polls < WAIT_CNT_MAX) line_st.polls = line_st.polls + 9'd1;
          // slave never pulled SDA low in time: abort with a stop
          if (line_st.polls > {1'b0, timeout_reg}) begin
            line_st.sda = 1'b0;
            line_st.ph  = PH_WA_S1;
          end
        end
      end
      PH_WA_S1: begin
        line_st.scl = 1'b1;
        line_st.ph  = PH_WA_S2;
      end
      PH_WA_S2: begin
        line_st.sda = 1'b1;
        line_st.ph  = PH_WA_S3;
      end
      PH_WA_S3: begin
        line_st.scl = 1'b0;
        fin  = 1'b1;
        fail = 1'b1;
      end
      PH_RD_HI: begin
        line_st.scl = 1'b1;
        line_st.ph  = PH_RD_LO;
      end
      PH_RD_LO: begin
        line_st.shreg = {line_st.shreg[6:0], t.sda_sample};
        line_st.scl   = 1'b0;
        line_st.nbits = line_st.nbits + 4'd1;
        line_st.ph    = (line_st.nbits >= BITS_PER_BYTE) ? PH_AK_SDA : PH_RD_HI;
      end
      PH_AK_SDA: begin
        line_st.sda = ~line_st.ack_bit;
        line_st.ph  = PH_AK_HI;
      end
      PH_AK_HI: begin
        line_st.scl = 1'b1;
        line_st.ph  = PH_AK_LO;
      end
      PH_AK_LO: begin
        line_st.scl = 1'b0;
        if (line_st.ack_bit) line_st.ph = PH_AK_REL;
        else fin = 1'b1;
      end
      PH_AK_REL: begin
        line_st.sda = 1'b1;
        fin = 1'b1;
      end
      default: line_st.ph = PH_IDLE;
    endcase
    if (fin) line_st.ph = PH_IDLE;

    r.scl_level  = line_st.scl;
    r.sda_level  = line_st.sda;
    r.busy_res   = (line_st.ph != PH_IDLE);
    r.done_res   = fin;
    r.read_data  = line_st.shreg;
    r.ack_failed = fail;
    return r;
  endfunction

  // Offer one tick, wait for the transaction, then queue its expected lines
  task automatic send_tick(input tick_in_t t, input logic typed, input tick_out_t typed_out);
    tick_out_t predicted;
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 17) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid               <= 1'b1;
    in_ch.command_valid       <= t.command_valid;
    in_ch.operation           <= t.operation;
    in_ch.write_data          <= t.write_data;
    in_ch.send_ack_after_read <= t.send_ack_after_read;
    in_ch.sda_sample          <= t.sda_sample;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = advance_line(t);
    pending_lines.push_back(typed ? typed_out : predicted);
    n_ticks++;
  endtask

  // Stop offering and wait until every tick has produced its result
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [7:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    timeout_reg = value;
    n_cfg_writes++;
  endtask

  // How many high polls the emulated slave answers with before pulling SDA low
  function automatic int unsigned pick_ack_delay();
    int unsigned pct;
    pct = (timeout_reg > 8'd32) ? 8 : 40;
    if ($urandom_range(0, 99) < pct) return timeout_reg + 1 + $urandom_range(0, 1);
    if ($urandom_range(0, 9) == 0) return timeout_reg;
    return $urandom_range(0, 3);
  endfunction

  // Issue one command and keep ticking until the sequencer is idle again
  task automatic run_command(input logic cv, input logic [2:0] op, input logic [7:0] wd,
                             input logic ak, input int unsigned ack_after);
    tick_in_t t;
    t.command_valid       = cv;
    t.operation           = op;
    t.write_data          = wd;
    t.send_ack_after_read = ak;
    t.sda_sample          = 1'($urandom_range(0, 1));
    send_tick(t, 1'b0, '0);
    if (cv) n_cmds++;
    while (line_st.ph != PH_IDLE) begin
      // occasional command while busy, which must be ignored
      t.command_valid       = ($urandom_range(0, 9) == 0);
      t.operation           = 3'($urandom_range(0, 7));
      t.write_data          = 8'($urandom);
      t.send_ack_after_read = 1'($urandom_range(0, 1));
      if (line_st.ph == PH_WA_POLL) t.sda_sample = (line_st.polls >= ack_after) ? 1'b0 : 1'b1;
      else t.sda_sample = 1'($urandom_range(0, 1));
      send_tick(t, 1'b0, '0);
    end
  endtask

  // A bus transfer: start, address, then data bytes, then stop
  task automatic run_frame();
    int unsigned n;
    n = $urandom_range(1, 3);
    run_command(1'b1, OP_START, 8'($urandom), 1'($urandom_range(0, 1)), 0);
    run_command(1'b1, OP_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), 0);
    run_command(1'b1, OP_WAIT, 8'($urandom), 1'($urandom_range(0, 1)), pick_ack_delay());
    repeat (n) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          run_command(1'b1, OP_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), 0);
          run_command(1'b1, OP_WAIT, 8'($urandom), 1'($urandom_range(0, 1)),
                      pick_ack_delay());
        end
        2: run_command(1'b1, OP_READ, 8'($urandom), 1'($urandom_range(0, 1)), 0);
        default: begin
          run_command(1'b1, OP_READ, 8'($urandom), 1'b0, 0);
          run_command(1'b1, $urandom_range(0, 1) ? OP_ACK : OP_NACK, 8'($urandom), 1'b0, 0);
        end
      endcase
    end
    run_command(1'b1, OP_STOP, 8'($urandom), 1'($urandom_range(0, 1)), 0);
  endtask

  // Mostly well-formed frames, some idle ticks, ignored codes and lone commands
  task automatic random_step();
    case ($urandom_range(0, 9))
      0: run_command(1'b0, 3'($urandom_range(0, 7)), 8'($urandom),
                     1'($urandom_range(0, 1)), 0);
      1: run_command(1'b1, OP_UNUSED, 8'($urandom), 1'($urandom_range(0, 1)), 0);
      2: run_command(1'b1, 3'($urandom_range(0, 6)), 8'($urandom),
                     1'($urandom_range(0, 1)), pick_ack_delay());
      default: run_frame();
    endcase
  endtask

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result();
    tick_out_t want;
    if (pending_lines.size() == 0) begin
      $error("result transaction with no tick pending");
      mismatch_count++;
    end else begin
      want = pending_lines.pop_front();
      compare_field("scl_level", 8'(want.scl_level), 8'(out_ch.scl_level));
      compare_field("sda_level", 8'(want.sda_level), 8'(out_ch.sda_level));
      compare_field("busy_res", 8'(want.busy_res), 8'(out_ch.busy_res));
      compare_field("done_res", 8'(want.done_res), 8'(out_ch.done_res));
      compare_field("read_data", want.read_data, out_ch.read_data);
      compare_field("ack_failed", 8'(want.ack_failed), 8'(out_ch.ack_failed));
    end
    if (out_ch.done_res === 1'b1) n_done_seen++;
    if (out_ch.ack_failed === 1'b1) n_fail_seen++;
  endtask

  // Result side: check each transaction, random back-pressure, long hold-offs
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned holds_taken;
    hold_left   = 0;
    holds_taken = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_result();
      if (holds_taken != hold_requests) begin
        holds_taken = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !gaps_on || ($urandom_range(0, 99) >= 17);
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    tick_in_t    t;
    logic [7:0]  cfg_vals [N_PHASES];
    int unsigned budgets  [N_PHASES];
    int unsigned start_ticks;
    bit          paused;

    rst_n                     <= 1'b0;
    cfg_we                    <= 1'b0;
    cfg_wdata                 <= '0;
    in_ch.valid               <= 1'b0;
    in_ch.command_valid       <= 1'b0;
    in_ch.operation           <= '0;
    in_ch.write_data          <= '0;
    in_ch.send_ack_after_read <= 1'b0;
    in_ch.sda_sample          <= 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    line_st.ph      = PH_IDLE;
    line_st.shreg   = '0;
    line_st.nbits   = '0;
    line_st.polls   = '0;
    line_st.ack_bit = 1'b0;
    line_st.scl     = 1'b1;
    line_st.sda     = 1'b1;
    timeout_reg     = ACK_TIMEOUT_RST;

    // Directed rows at the reset timeout
    foreach (dir_rows[i]) begin
      t.command_valid       = dir_rows[i].cv;
      t.operation           = dir_rows[i].op;
      t.write_data          = dir_rows[i].wd;
      t.send_ack_after_read = dir_rows[i].ak;
      t.sda_sample          = dir_rows[i].sda;
      send_tick(t, dir_rows[i].typed, dir_rows[i].want);
      if (dir_rows[i].cv) n_cmds++;
      t.command_valid = 1'b0;
      repeat (dir_rows[i].trail) send_tick(t, 1'b0, '0);
    end

    // Random phases, one timeout setting each
    cfg_vals[0] = 8'd0;
    cfg_vals[1] = 8'd255;
    cfg_vals[2] = 8'($urandom_range(2, 30));
    cfg_vals[3] = 8'd1;
    budgets[0]  = 170;
    budgets[1]  = 140;
    budgets[2]  = 170;
    budgets[3]  = 140;
    for (int p = 0; p < N_PHASES; p++) begin
      write_timeout(cfg_vals[p]);
      gaps_on = (p != 3);
      if (p == 2) hold_requests++;
      start_ticks = n_ticks;
      paused      = 1'b0;
      while (n_ticks - start_ticks < budgets[p]) begin
        // sender pause halfway through the first phase
        if (p == 0 && !paused && n_ticks - start_ticks >= budgets[p] / 2) begin
          drain();
          paused = 1'b1;
        end
        random_step();
      end
    end
    gaps_on = 1'b1;

    drain();
    repeat (4) @(posedge clk);
    $display("Ran %0d ticks carrying %0d commands; %0d completions, %0d acknowledge timeouts",
             n_ticks, n_cmds, n_done_seen, n_fail_seen);
    $display("Timeout register: reset value plus %0d written settings", n_cfg_writes);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- i2c_master_bit_sequencer.f -----
rtl/i2cm_pkg.sv
rtl/i2cm_if.sv
rtl/i2cm_step.sv
rtl/i2c_master_bit_sequencer.sv
rtl/i2cm_checker.sv
test/tb_i2c_master_bit_sequencer.sv
